>>> rtl/btp_pkg.sv
// Shared types, character codes and limits for the bencode token parser.
`timescale 1ns / 1ps

package btp_pkg;

  // Default bound on container nesting.
  localparam int MaxDepthDefault = 16;

  // Field widths fixed by the interface.
  localparam int ByteW   = 8;
  localparam int IntW    = 63;
  localparam int LenW    = 32;
  localparam int NestW   = 5;
  localparam int DigitW  = 4;

  // Stream characters that steer the parser.
  localparam logic [ByteW-1:0] ChInt   = 8'h69;  // 'i'
  localparam logic [ByteW-1:0] ChList  = 8'h6C;  // 'l'
  localparam logic [ByteW-1:0] ChDict  = 8'h64;  // 'd'
  localparam logic [ByteW-1:0] ChEnd   = 8'h65;  // 'e'
  localparam logic [ByteW-1:0] ChZero  = 8'h30;  // '0'
  localparam logic [ByteW-1:0] ChNine  = 8'h39;  // '9'

  // Largest integer value and largest string length.
  localparam logic [IntW-1:0]   IntMax   = {IntW{1'b1}};
  localparam logic [IntW-1:0]   IntDiv10 = IntMax / 63'd10;
  localparam logic [DigitW-1:0] IntRem10 = DigitW'(IntMax % 63'd10);
  localparam logic [LenW-1:0]   LenMax   = {LenW{1'b1}};

  // Parser phases.
  typedef enum logic [2:0] {
    PhValue = 3'd0,
    PhInt   = 3'd1,
    PhLen   = 3'd2,
    PhStr   = 3'd3,
    PhErr   = 3'd4
  } phase_e;

  // Event codes reported with each result word.
  typedef enum logic [2:0] {
    EvInt    = 3'd0,
    EvSByte  = 3'd1,
    EvEmpty  = 3'd2,
    EvLOpen  = 3'd3,
    EvDOpen  = 3'd4,
    EvLClose = 3'd5,
    EvDClose = 3'd6,
    EvErr    = 3'd7
  } event_e;

  // Largest accumulator value that can take one more digit without
  // passing IntMax: (IntMax - digit) / 10.
  function automatic logic [IntW-1:0] acc_limit(input logic [DigitW-1:0] digit);
    logic [IntW-1:0] lim;
    lim = (digit > IntRem10) ? (IntDiv10 - IntW'(1)) : IntDiv10;
    return lim;
  endfunction

endpackage

>>> rtl/bencode_token_parser_core.sv
// Top level of the bencode token parser: input register, parse logic and result register.
`timescale 1ns / 1ps

// A byte accepted is held in the input register, and any result word that it yields
// then enters the result register, where it waits until it is taken.
// The core takes one byte per cycle while the result register can drain; a held-off
// result stalls the input only once both registers are full.
// Reset clears the phase, number, length, depth and both valid flags; the
// container kind stack is not cleared and is only read after a push.
module bencode_token_parser_core import btp_pkg::*; #(
  parameter int MAX_DEPTH = MaxDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ByteW-1:0]  in_byte_i,
  input  logic              new_stream_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        event_kind_o,
  output logic [IntW-1:0]   int_value_o,
  output logic [ByteW-1:0]  data_byte_o,
  output logic              string_last_o,
  output logic [NestW-1:0]  nest_depth_o,
  output logic              saturated_o
);

  localparam int DepthW = $clog2(MAX_DEPTH + 1);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_DEPTH);

  // Input register.
  logic             s1_v_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_new_q;
  logic             s1_go;
  logic             out_free;

  // Parse state.
  phase_e            phase_q, phase_d, phase_c;
  logic [IntW-1:0]   acc_q, acc_d, acc_c;
  logic              ovf_q, ovf_d, ovf_c;
  logic [LenW-1:0]   rem_q, rem_d, rem_c;
  logic [DepthW-1:0] depth_q, depth_d, depth_c;
  logic [MAX_DEPTH-1:0] stk_q, stk_d;
  logic [MAX_DEPTH:0]   stk_push, stk_pop;

  // Result of the current byte.
  logic              res_v;
  event_e            res_kind;
  logic [IntW-1:0]   res_int;
  logic [ByteW-1:0]  res_byte;
  logic              res_last;
  logic              res_sat;

  // Result register.
  logic              out_v_q;
  logic [2:0]        kind_q;
  logic [IntW-1:0]   int_q;
  logic [ByteW-1:0]  byte_q;
  logic              last_q;
  logic [NestW-1:0]  nest_q;
  logic              sat_q;
  logic [DepthW+NestW-1:0] depth_ext;

  // Digit arithmetic.
  logic              is_digit;
  logic [DigitW-1:0] digit;
  logic [ByteW-1:0]  digit_full;
  logic              acc_over;
  logic [IntW-1:0]   acc_next;
  logic [LenW-1:0]   len_val;

  // Handshake: the result register frees when empty or drained this cycle.
  assign out_free   = !out_v_q || out_ready_i;
  assign s1_go      = s1_v_q && out_free;
  assign in_ready_o = !s1_v_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= in_byte_i;
      s1_new_q  <= new_stream_i;
    end
  end

  // A new stream clears the parse state before the byte is looked at.
  assign phase_c = s1_new_q ? PhValue : phase_q;
  assign acc_c   = s1_new_q ? '0 : acc_q;
  assign ovf_c   = s1_new_q ? 1'b0 : ovf_q;
  assign rem_c   = s1_new_q ? '0 : rem_q;
  assign depth_c = s1_new_q ? '0 : depth_q;

  // Multiply-add of one decimal digit, clamped at the integer maximum.
  assign is_digit   = (s1_byte_q >= ChZero) && (s1_byte_q <= ChNine);
  assign digit_full = s1_byte_q - ChZero;
  assign digit      = digit_full[DigitW-1:0];
  assign acc_over   = acc_c > acc_limit(digit);
  assign acc_next   = acc_over ? IntMax
                    : ({acc_c[IntW-4:0], 3'b000} + {acc_c[IntW-2:0], 1'b0}
                       + IntW'(digit));
  assign len_val    = (acc_c > IntW'(LenMax)) ? LenMax : acc_c[LenW-1:0];

  // Stack moves: the top entry always sits at bit 0.
  assign stk_push = {stk_q, (s1_byte_q == ChDict)};
  assign stk_pop  = {1'b0, stk_q} >> 1;

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    ovf_d    = ovf_q;
    rem_d    = rem_q;
    depth_d  = depth_q;
    stk_d    = stk_q;
    res_v    = 1'b0;
    res_kind = EvErr;
    res_int  = '0;
    res_byte = '0;
    res_last = 1'b0;
    res_sat  = 1'b0;
    if (s1_go) begin
      phase_d = phase_c;
      acc_d   = acc_c;
      ovf_d   = ovf_c;
      rem_d   = rem_c;
      depth_d = depth_c;
      case (phase_c)
        PhInt: begin
          if (is_digit) begin
            acc_d = acc_next;
            ovf_d = ovf_c | acc_over;
          end else begin
            res_v    = 1'b1;
            res_kind = EvInt;
            res_int  = acc_c;
            res_sat  = ovf_c;
            acc_d    = '0;
            ovf_d    = 1'b0;
            phase_d  = PhValue;
          end
        end
        PhLen: begin
          if (is_digit) begin
            acc_d = acc_next;
            ovf_d = ovf_c | acc_over;
          end else begin
            acc_d = '0;
            ovf_d = 1'b0;
            if (len_val == '0) begin
              res_v    = 1'b1;
              res_kind = EvEmpty;
              phase_d  = PhValue;
            end else begin
              rem_d   = len_val;
              phase_d = PhStr;
            end
          end
        end
        PhStr: begin
          rem_d    = rem_c - LenW'(1);
          res_v    = 1'b1;
          res_kind = EvSByte;
          res_byte = s1_byte_q;
          res_last = (rem_c == LenW'(1));
          if (rem_c == LenW'(1)) begin
            phase_d = PhValue;
          end
        end
        PhValue: begin
          if (s1_byte_q == ChInt) begin
            acc_d   = '0;
            ovf_d   = 1'b0;
            phase_d = PhInt;
          end else if (is_digit) begin
            acc_d   = IntW'(digit);
            ovf_d   = 1'b0;
            phase_d = PhLen;
          end else if ((s1_byte_q == ChList) || (s1_byte_q == ChDict)) begin
            res_v = 1'b1;
            if (depth_c >= DepthMax) begin
              res_kind = EvErr;
              phase_d  = PhErr;
            end else begin
              stk_d    = stk_push[MAX_DEPTH-1:0];
              depth_d  = depth_c + DepthW'(1);
              res_kind = (s1_byte_q == ChDict) ? EvDOpen : EvLOpen;
            end
          end else if (s1_byte_q == ChEnd) begin
            res_v = 1'b1;
            if (depth_c == '0) begin
              res_kind = EvErr;
              phase_d  = PhErr;
            end else begin
              stk_d    = stk_pop[MAX_DEPTH-1:0];
              depth_d  = depth_c - DepthW'(1);
              res_kind = stk_q[0] ? EvDClose : EvLClose;
            end
          end else begin
            res_v    = 1'b1;
            res_kind = EvErr;
            phase_d  = PhErr;
          end
        end
        default: begin
          res_v    = 1'b1;
          res_kind = EvErr;
          phase_d  = PhErr;
        end
      endcase
    end
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhValue;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      rem_q   <= '0;
      depth_q <= '0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      rem_q   <= rem_d;
      depth_q <= depth_d;
    end
  end

  // The kind stack holds only payload and needs no reset.
  always_ff @(posedge clk_i) begin
    stk_q <= stk_d;
  end

  // Depth reported as its low five bits.
  assign depth_ext = {{NestW{1'b0}}, depth_d};

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= res_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_v) begin
      kind_q <= res_kind;
      int_q  <= res_int;
      byte_q <= res_byte;
      last_q <= res_last;
      nest_q <= depth_ext[NestW-1:0];
      sat_q  <= res_sat;
    end
  end

  assign out_valid_o   = out_v_q;
  assign event_kind_o  = kind_q;
  assign int_value_o   = int_q;
  assign data_byte_o   = byte_q;
  assign string_last_o = last_q;
  assign nest_depth_o  = nest_q;
  assign saturated_o   = sat_q;

  // The nesting depth never passes the stack size.
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthMax)
    else $error("nesting depth above the stack size");

  // A string in progress always has bytes left to take.
  a_str_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhStr) |-> (rem_q != '0))
    else $error("string phase with no bytes remaining");

  // The last marker only comes with a string byte.
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && string_last_o) |-> (event_kind_o == EvSByte))
    else $error("string last marker on a non-string word");

  // A clamped integer always reports the integer maximum.
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (event_kind_o == EvInt && int_value_o == IntMax))
    else $error("saturated flag without a clamped integer");

  // In the error phase every byte yields an error word.
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && !s1_new_q && phase_q == PhErr) |=>
      (out_valid_o && event_kind_o == EvErr))
    else $error("error phase did not report an error word");

endmodule
